/* design/arq_pkg.sv */
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ endpoint package
// Shared widths, table sizing, codes and the structs passed between the
// sequencer and the client table, plus the sequencer's result struct.
// ----------------------------------------------------------------------------
package arq_pkg;

    localparam int MAX_CLIENTS = 16;
    localparam int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int ADDR_W      = 48;
    localparam int ID_W        = 16;
    localparam int PORT_W      = 16;
    localparam int SIZE_W      = 16;

    localparam logic PKT_KIND_ACK = 1'b1;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [MAX_CLIENTS-1:0] valid_vec_t;

    typedef struct packed {
        logic en;
        idx_t idx;
    } tbl_rd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   exp_id;
    } tbl_entry_t;

    typedef struct packed {
        logic       en;
        idx_t       idx;
        tbl_entry_t entry;
    } tbl_wr_t;

    typedef struct packed {
        logic              send_ack;
        logic [ADDR_W-1:0] ack_address;
        logic [PORT_W-1:0] ack_dest_port;
        logic [PORT_W-1:0] ack_source_port;
        logic [ID_W-1:0]   ack_id;
        logic [SIZE_W-1:0] ack_size;
        logic              deliver;
        logic              send_advanced;
        logic              table_full;
    } res_t;

endpackage

/* design/arq_if.sv */
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ endpoint channels
// Valid/ready channels for arriving packet words and result words.
// ----------------------------------------------------------------------------
interface arq_pkt_if;
    logic                        valid;
    logic                        ready;
    logic                        is_ack;
    logic [arq_pkg::ID_W-1:0]    packet_id;
    logic [arq_pkg::ADDR_W-1:0]  source_address;
    logic [arq_pkg::PORT_W-1:0]  source_port;
    logic [arq_pkg::PORT_W-1:0]  dest_port;
    logic [arq_pkg::SIZE_W-1:0]  payload_size;

    modport source (
        output valid, is_ack, packet_id, source_address, source_port, dest_port,
               payload_size,
        input  ready
    );

    modport sink (
        input  valid, is_ack, packet_id, source_address, source_port, dest_port,
               payload_size,
        output ready
    );
endinterface

interface arq_res_if;
    logic                        valid;
    logic                        ready;
    logic                        send_ack;
    logic [arq_pkg::ADDR_W-1:0]  ack_address;
    logic [arq_pkg::PORT_W-1:0]  ack_dest_port;
    logic [arq_pkg::PORT_W-1:0]  ack_source_port;
    logic [arq_pkg::ID_W-1:0]    ack_id;
    logic [arq_pkg::SIZE_W-1:0]  ack_size;
    logic                        deliver;
    logic                        send_advanced;
    logic                        table_full;

    modport source (
        output valid, send_ack, ack_address, ack_dest_port, ack_source_port, ack_id,
               ack_size, deliver, send_advanced, table_full,
        input  ready
    );

    modport sink (
        input  valid, send_ack, ack_address, ack_dest_port, ack_source_port, ack_id,
               ack_size, deliver, send_advanced, table_full,
        output ready
    );
endinterface

/* design/arq_table.sv */
// ----------------------------------------------------------------------------
// Client table
// Per-sender address and expected id memory with registered read, plus
// valid flags cleared at reset.
// ----------------------------------------------------------------------------
module arq_table (
    input  logic                clk,
    input  logic                rst_n,
    input  arq_pkg::tbl_rd_t    rd,
    input  arq_pkg::tbl_wr_t    wr,
    output arq_pkg::tbl_entry_t rd_data,
    output arq_pkg::valid_vec_t valid
);

    arq_pkg::tbl_entry_t mem [arq_pkg::MAX_CLIENTS];
    arq_pkg::valid_vec_t valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.entry;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= 1'b1;
        end
    end

    assign valid = valid_reg;

endmodule

/* design/arq_ctrl.sv */
// ----------------------------------------------------------------------------
// Endpoint sequencer
// Walks the client table through one address comparator, decides ack and
// delivery, keeps the send sequence and holds the result word.
// ----------------------------------------------------------------------------
module arq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    arq_pkt_if.sink             pkt,
    arq_res_if.source           res,
    output arq_pkg::tbl_rd_t    rd,
    output arq_pkg::tbl_wr_t    wr,
    input  arq_pkg::tbl_entry_t rd_data,
    input  arq_pkg::valid_vec_t valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } state_t;

    localparam arq_pkg::idx_t LAST_IDX = arq_pkg::IDX_W'(arq_pkg::MAX_CLIENTS - 1);

    state_t                       state_reg, state_next;
    logic [arq_pkg::ID_W-1:0]     seq_reg, seq_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         issue_reg, issue_next;
    logic                         pend_reg, pend_next;
    arq_pkg::idx_t                scan_idx_reg, scan_idx_next;
    arq_pkg::idx_t                cmp_idx_reg, cmp_idx_next;
    logic                         found_reg, found_next;
    logic                         free_found_reg, free_found_next;
    arq_pkg::idx_t                hit_idx_reg, hit_idx_next;
    arq_pkg::idx_t                free_idx_reg, free_idx_next;
    logic [arq_pkg::ID_W-1:0]     exp_reg, exp_next;

    logic [arq_pkg::ID_W-1:0]     item_id_reg;
    logic [arq_pkg::ADDR_W-1:0]   item_addr_reg;
    logic [arq_pkg::PORT_W-1:0]   item_sport_reg;
    logic [arq_pkg::PORT_W-1:0]   item_dport_reg;
    logic [arq_pkg::SIZE_W-1:0]   item_size_reg;
    arq_pkg::res_t                res_reg, res_next;
    arq_pkg::res_t                out_reg;

    logic                         accept;
    logic                         out_fire;
    logic                         load_out;
    logic                         hit;
    logic                         known;
    logic                         id_le;
    logic                         id_eq;
    logic [arq_pkg::ID_W-1:0]     cur_exp;
    arq_pkg::idx_t                sel_idx;

    assign pkt.ready = (state_reg == ST_IDLE);
    assign accept    = pkt.valid && pkt.ready;
    assign out_fire  = out_valid_reg && res.ready;

    assign hit     = pend_reg && valid[cmp_idx_reg] && (rd_data.addr == item_addr_reg);
    assign known   = found_reg || free_found_reg;
    assign cur_exp = found_reg ? exp_reg : '0;
    assign sel_idx = found_reg ? hit_idx_reg : free_idx_reg;
    assign id_le   = (item_id_reg <= cur_exp);
    assign id_eq   = (item_id_reg == cur_exp);

    always_comb
    begin
        state_next      = state_reg;
        seq_next        = seq_reg;
        out_valid_next  = out_valid_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        exp_next        = exp_reg;
        res_next        = res_reg;
        load_out        = 1'b0;
        rd.en           = 1'b0;
        rd.idx          = scan_idx_reg;
        wr              = '0;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pkt.is_ack == arq_pkg::PKT_KIND_ACK)
                    begin
                        res_next = '0;
                        if (pkt.packet_id == seq_reg)
                        begin
                            seq_next               = seq_reg + 16'd1;
                            res_next.send_advanced = 1'b1;
                        end
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        scan_idx_next   = '0;
                        issue_next      = 1'b1;
                        pend_next       = 1'b0;
                        found_next      = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                rd.en = issue_reg;
                if (issue_reg)
                begin
                    cmp_idx_next = scan_idx_reg;
                    pend_next    = 1'b1;
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + arq_pkg::idx_t'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (hit)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    exp_next     = rd_data.exp_id;
                    issue_next   = 1'b0;
                    state_next   = ST_DECIDE;
                end
                else if (pend_reg)
                begin
                    if (!valid[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                res_next = '0;
                if (!known)
                begin
                    res_next.table_full = 1'b1;
                end
                else
                begin
                    if (id_le)
                    begin
                        res_next.send_ack        = 1'b1;
                        res_next.ack_address     = item_addr_reg;
                        res_next.ack_dest_port   = item_sport_reg;
                        res_next.ack_source_port = item_dport_reg;
                        res_next.ack_id          = item_id_reg;
                        res_next.ack_size        = item_size_reg;
                    end
                    res_next.deliver = id_eq;
                    // allocate a new sender and/or advance its expected id
                    wr.en           = id_eq || !found_reg;
                    wr.idx          = sel_idx;
                    wr.entry.addr   = item_addr_reg;
                    wr.entry.exp_id = id_eq ? (cur_exp + 16'd1) : cur_exp;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || out_fire)
                begin
                    out_valid_next = 1'b1;
                    load_out       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seq_reg        <= '0;
            out_valid_reg  <= 1'b0;
            issue_reg      <= 1'b0;
            pend_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            hit_idx_reg    <= '0;
            free_idx_reg   <= '0;
            exp_reg        <= '0;
            res_reg        <= '0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            seq_reg        <= seq_next;
            out_valid_reg  <= out_valid_next;
            issue_reg      <= issue_next;
            pend_reg       <= pend_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_idx_reg    <= cmp_idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            hit_idx_reg    <= hit_idx_next;
            free_idx_reg   <= free_idx_next;
            exp_reg        <= exp_next;
            res_reg        <= res_next;
            if (load_out)
            begin
                out_reg <= res_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_id_reg    <= pkt.packet_id;
            item_addr_reg  <= pkt.source_address;
            item_sport_reg <= pkt.source_port;
            item_dport_reg <= pkt.dest_port;
            item_size_reg  <= pkt.payload_size;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.send_ack        = out_reg.send_ack;
    assign res.ack_address     = out_reg.ack_address;
    assign res.ack_dest_port   = out_reg.ack_dest_port;
    assign res.ack_source_port = out_reg.ack_source_port;
    assign res.ack_id          = out_reg.ack_id;
    assign res.ack_size        = out_reg.ack_size;
    assign res.deliver         = out_reg.deliver;
    assign res.send_advanced   = out_reg.send_advanced;
    assign res.table_full      = out_reg.table_full;

endmodule

/* design/stop_and_wait_arq_endpoint_top.sv */
// ----------------------------------------------------------------------------
// Stop-and-wait ARQ endpoint, receive side
// Handles arriving packets: advances the send sequence on a matching ack,
// and for data packets finds or allocates the sender and may ack or deliver.
//
// Usage:
//   pkt : one packet word per valid/ready handshake.
//   res : one result word per packet, held in an output register.
//   Ready is high only while the sequencer is idle; it drops for the whole
//   packet. An ack packet's result is registered on acceptance and loads
//   into the output register once that register is free. A data packet
//   walks the client table one entry per cycle through a single 48-bit
//   address comparator with a registered memory read, stopping at a hit or
//   after the last entry; a decide state then builds its result word.
//   Ready returns as the result word loads, so the next packet is taken
//   only once the previous packet's result word has loaded.
//   A new packet is taken while a result word still waits; its own result
//   then waits in the sequencer until res takes the previous word.
//   Reset clears the send sequence, all client valid flags and both
//   channels; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module stop_and_wait_arq_endpoint_top (
    input  logic      clk,
    input  logic      rst_n,
    arq_pkt_if.sink   pkt,
    arq_res_if.source res
);

    arq_pkg::tbl_rd_t    rd;
    arq_pkg::tbl_wr_t    wr;
    arq_pkg::tbl_entry_t rd_data;
    arq_pkg::valid_vec_t valid;

    arq_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .pkt     (pkt),
        .res     (res),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data),
        .valid   (valid)
    );

    arq_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data),
        .valid   (valid)
    );

endmodule

/* design/arq_checker.sv */
// ----------------------------------------------------------------------------
// Endpoint port checker
// Watches the endpoint channels for sequencing and result consistency.
// ----------------------------------------------------------------------------
module arq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       pkt_valid,
    input logic                       pkt_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic                       send_ack,
    input logic [arq_pkg::ADDR_W-1:0] ack_address,
    input logic [arq_pkg::PORT_W-1:0] ack_dest_port,
    input logic [arq_pkg::PORT_W-1:0] ack_source_port,
    input logic [arq_pkg::ID_W-1:0]   ack_id,
    input logic [arq_pkg::SIZE_W-1:0] ack_size,
    input logic                       deliver,
    input logic                       send_advanced,
    input logic                       table_full
);

    // one packet at a time: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_ready |=> !pkt_ready)
        else $error("endpoint ready right after accepting a packet");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !send_ack |-> ack_address == '0 && ack_dest_port == '0 &&
            ack_source_port == '0 && ack_id == '0 && ack_size == '0)
        else $error("ack fields nonzero without an ack");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (send_advanced || table_full || deliver) |->
            (deliver ? send_ack : !send_ack) && !(send_advanced && table_full))
        else $error("inconsistent result flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(send_ack) &&
            $stable(ack_id) && $stable(deliver) && $stable(table_full))
        else $error("stalled result word changed");

endmodule

bind stop_and_wait_arq_endpoint_top arq_checker u_arq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pkt_valid       (pkt.valid),
    .pkt_ready       (pkt.ready),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .send_ack        (res.send_ack),
    .ack_address     (res.ack_address),
    .ack_dest_port   (res.ack_dest_port),
    .ack_source_port (res.ack_source_port),
    .ack_id          (res.ack_id),
    .ack_size        (res.ack_size),
    .deliver         (res.deliver),
    .send_advanced   (res.send_advanced),
    .table_full      (res.table_full)
);
